// ----- hdl/joystick_velocity_conditioner_core_macros.svh -----
// assertion macros for the joystick velocity conditioner
// included by the modules that carry concurrent checks; no other dependencies
`ifndef JOYSTICK_VELOCITY_CONDITIONER_CORE_MACROS_SVH
`define JOYSTICK_VELOCITY_CONDITIONER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// check that is switched off while reset is asserted
`define JVC_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
	else $error("jvc assertion failed");
// check that also holds while reset is asserted
`define JVC_ASSERT_ALWAYS(lbl, ck, prop) \
	lbl: assert property (@(posedge ck) prop) \
	else $error("jvc assertion failed");
`else
`define JVC_ASSERT(lbl, ck, rn, prop)
`define JVC_ASSERT_ALWAYS(lbl, ck, prop)
`endif

`endif

// ----- hdl/jvc_pkg.sv -----
// shared types and constants of the joystick velocity conditioner
// used by every module of the block; no dependencies
package jvc_pkg;

	localparam int AXIS_W  = 16;
	localparam int SPEED_W = 15;
	localparam int GAIN_W  = 16;
	localparam int VEL_W   = 24;
	localparam int QUO_W   = 23;
	localparam int APB_AW  = 4;
	localparam int APB_DW  = 32;

	// slow limit = floor((4*max_speed + 5) / 10) via reciprocal 2^20/10, rounded up
	localparam int              SLOW_N_W   = 18;
	localparam int              SLOW_P_W   = 35;
	localparam int              SLOW_SHIFT = 20;
	localparam logic [16:0]     SLOW_RECIP = 17'd104858;

	localparam logic [0:0] CMD_SAMPLE = 1'b0;
	localparam logic [0:0] CMD_TICK   = 1'b1;

	localparam logic [1:0] KIND_DRIVE = 2'd0;
	localparam logic [1:0] KIND_ZERO  = 2'd1;
	localparam logic [1:0] KIND_STOP  = 2'd2;

	localparam logic [1:0] AXIS_X   = 2'd0;
	localparam logic [1:0] AXIS_Y   = 2'd1;
	localparam logic [1:0] AXIS_ROT = 2'd2;

	localparam logic [1:0] REG_MAX_SPEED   = 2'd0;
	localparam logic [1:0] REG_LINEAR_GAIN = 2'd1;
	localparam logic [1:0] REG_TURN_GAIN   = 2'd2;
	localparam logic [1:0] REG_TIMEOUT_MS  = 2'd3;

	localparam logic [SPEED_W-1:0] MAX_SPEED_RST   = 15'd32767;
	localparam logic [GAIN_W-1:0]  LINEAR_GAIN_RST = 16'd256;
	localparam logic [GAIN_W-1:0]  TURN_GAIN_RST   = 16'd256;
	localparam logic [15:0]        TIMEOUT_MS_RST  = 16'd150;

	typedef struct packed {
		logic                     cmd;
		logic signed [AXIS_W-1:0] axis_x;
		logic signed [AXIS_W-1:0] axis_y;
		logic signed [AXIS_W-1:0] axis_rot;
		logic                     enable_button;
		logic                     slow_button;
		logic [31:0]              time_ms;
	} in_t;

	typedef struct packed {
		logic [1:0]              kind;
		logic signed [VEL_W-1:0] lin_x;
		logic signed [VEL_W-1:0] lin_y;
		logic signed [VEL_W-1:0] ang_z;
	} out_t;

	typedef struct packed {
		logic [SPEED_W-1:0] max_speed;
		logic [GAIN_W-1:0]  linear_gain;
		logic [GAIN_W-1:0]  turn_gain;
		logic [15:0]        timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic       load;
		logic       calc_lim;
		logic       tick;
		logic       push;
		logic       sq;
		logic       gain;
		logic       div_init;
		logic       div_step;
		logic       store;
		logic       emit;
		logic [1:0] axis;
	} cmd_t;

	typedef struct packed {
		logic is_tick;
		logic send;
		logic curve;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

// ----- hdl/jvc_regs.sv -----
// configuration register file on an apb-style port
// depends on jvc_pkg
module jvc_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [jvc_pkg::APB_AW-1:0]  paddr,
	input  logic [jvc_pkg::APB_DW-1:0]  pwdata,
	output logic [jvc_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output jvc_pkg::cfg_t               cfg
);

	jvc_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [1:0]    reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_speed   <= jvc_pkg::MAX_SPEED_RST;
			cfg_q.linear_gain <= jvc_pkg::LINEAR_GAIN_RST;
			cfg_q.turn_gain   <= jvc_pkg::TURN_GAIN_RST;
			cfg_q.timeout_ms  <= jvc_pkg::TIMEOUT_MS_RST;
		end else if (wr_en) begin
			case (reg_idx)
				jvc_pkg::REG_MAX_SPEED:   cfg_q.max_speed   <= pwdata[jvc_pkg::SPEED_W-1:0];
				jvc_pkg::REG_LINEAR_GAIN: cfg_q.linear_gain <= pwdata[jvc_pkg::GAIN_W-1:0];
				jvc_pkg::REG_TURN_GAIN:   cfg_q.turn_gain   <= pwdata[jvc_pkg::GAIN_W-1:0];
				jvc_pkg::REG_TIMEOUT_MS:  cfg_q.timeout_ms  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			jvc_pkg::REG_MAX_SPEED:   prdata = jvc_pkg::APB_DW'(cfg_q.max_speed);
			jvc_pkg::REG_LINEAR_GAIN: prdata = jvc_pkg::APB_DW'(cfg_q.linear_gain);
			jvc_pkg::REG_TURN_GAIN:   prdata = jvc_pkg::APB_DW'(cfg_q.turn_gain);
			jvc_pkg::REG_TIMEOUT_MS:  prdata = jvc_pkg::APB_DW'(cfg_q.timeout_ms);
			default:                  prdata = '0;
		endcase
	end

endmodule

// ----- hdl/jvc_ctrl.sv -----
// sequencing state machine: steps the datapath through one item at a time
// depends on jvc_pkg and the assertion macro header
`include "joystick_velocity_conditioner_core_macros.svh"

module jvc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          busy,
	input  jvc_pkg::sts_t sts,
	output jvc_pkg::cmd_t cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_LIM  = 4'd1;
	localparam logic [3:0] ST_TICK = 4'd2;
	localparam logic [3:0] ST_PUSH = 4'd3;
	localparam logic [3:0] ST_SQ   = 4'd4;
	localparam logic [3:0] ST_GAIN = 4'd5;
	localparam logic [3:0] ST_DIVI = 4'd6;
	localparam logic [3:0] ST_DIV  = 4'd7;
	localparam logic [3:0] ST_EMIT = 4'd8;

	logic [3:0] state_q, state_d;
	logic [1:0] axis_q, axis_d;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d  = state_q;
		axis_d   = axis_q;
		cmd      = '0;
		cmd.axis = axis_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_LIM;
				end
			end
			ST_LIM: begin
				cmd.calc_lim = 1'b1;
				state_d      = sts.is_tick ? ST_TICK : ST_PUSH;
			end
			ST_TICK: begin
				cmd.tick = 1'b1;
				state_d  = sts.send ? ST_EMIT : ST_IDLE;
			end
			ST_PUSH: begin
				cmd.push = 1'b1;
				axis_d   = jvc_pkg::AXIS_X;
				if (sts.curve) begin
					state_d = ST_SQ;
				end else begin
					state_d = sts.send ? ST_EMIT : ST_IDLE;
				end
			end
			ST_SQ: begin
				cmd.sq  = 1'b1;
				state_d = ST_GAIN;
			end
			ST_GAIN: begin
				cmd.gain = 1'b1;
				state_d  = ST_DIVI;
			end
			ST_DIVI: begin
				cmd.div_init = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) begin
					cmd.store = 1'b1;
					if (axis_q == jvc_pkg::AXIS_ROT) begin
						state_d = ST_EMIT;
					end else begin
						axis_d  = axis_q + 2'd1;
						state_d = ST_SQ;
					end
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= jvc_pkg::AXIS_X;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
		end
	end

	`JVC_ASSERT(a_emit_returns_idle, clk, arst_n, (state_q == ST_EMIT && sts.out_free) |=> (state_q == ST_IDLE))
	`JVC_ASSERT(a_rot_axis_emits, clk, arst_n, (state_q == ST_DIV && sts.div_done && axis_q == jvc_pkg::AXIS_ROT) |=> (state_q == ST_EMIT))
	`JVC_ASSERT(a_tick_branch, clk, arst_n, (state_q == ST_LIM && sts.is_tick) |=> (state_q == ST_TICK))

endmodule

// ----- hdl/jvc_dp.sv -----
// datapath: clamp, sliding window sums, square and gain multipliers shared by the axes,
// division by the window squared, dead man and link state, result register; uses jvc_pkg
module jvc_dp #(
	parameter int WINDOW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  jvc_pkg::in_t  item,
	input  jvc_pkg::cfg_t cfg,
	input  jvc_pkg::cmd_t cmd,
	output jvc_pkg::sts_t sts,
	input  logic          vel_stall,
	output logic          vel_valid,
	output jvc_pkg::out_t vel
);

	localparam int LOGW = (WINDOW > 1) ? $clog2(WINDOW) : 0;
	localparam bit POW2 = ((1 << LOGW) == WINDOW);
	localparam int K    = WINDOW * WINDOW;
	localparam int MW   = $clog2(32768 * WINDOW + 1);
	localparam int SW   = MW + 1;
	localparam int P1W  = 2 * MW;
	localparam int P2W  = P1W + jvc_pkg::GAIN_W;
	localparam int DW   = P2W - jvc_pkg::QUO_W;
	localparam logic [P2W-1:0] HALF = P2W'(K) << (jvc_pkg::QUO_W - 1);

	function automatic logic signed [15:0] clamp_axis(input logic signed [15:0] v,
		input logic [14:0] lim);
		logic signed [15:0] hi;
		logic signed [15:0] lo;
		hi = signed'({1'b0, lim});
		lo = -hi;
		if (v > hi) begin
			return hi;
		end else if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	jvc_pkg::in_t in_q;
	logic [jvc_pkg::SPEED_W-1:0] lim_q;

	logic signed [15:0] hx_q [WINDOW];
	logic signed [15:0] hy_q [WINDOW];
	logic signed [15:0] hr_q [WINDOW];
	logic signed [SW-1:0] sx_q, sy_q, sr_q;
	logic [31:0] last_stamp_q;
	logic        link_lost_q;
	logic        zero_sent_q;

	logic [1:0]                      kind_q;
	logic signed [jvc_pkg::VEL_W-1:0] lx_q, ly_q, az_q;
	logic [P1W-1:0] p1_q;
	logic [P2W-1:0] p2_q;
	logic           neg_q;

	logic                    vel_valid_q;
	jvc_pkg::out_t           vel_q;

	logic [jvc_pkg::SLOW_N_W-1:0] slow_n;
	logic [jvc_pkg::SLOW_P_W-1:0] slow_p;
	logic signed [15:0]           cx, cy;
	logic [31:0]                  age;
	logic                         lost;
	logic signed [SW-1:0]         sel, neg_sel;
	logic [MW-1:0]                mag;
	logic [jvc_pkg::GAIN_W-1:0]   gain_sel;
	logic [DW-1:0]                dvd;
	logic [jvc_pkg::QUO_W-1:0]    quo;
	logic                         div_done;
	logic [jvc_pkg::VEL_W-1:0]    quo_ext, res;

	// slow limit and clamped axes
	assign slow_n = jvc_pkg::SLOW_N_W'({cfg.max_speed, 2'b00}) + jvc_pkg::SLOW_N_W'(5);
	assign slow_p = jvc_pkg::SLOW_P_W'(slow_n) * jvc_pkg::SLOW_P_W'(jvc_pkg::SLOW_RECIP);
	assign cx     = clamp_axis(in_q.axis_x, lim_q);
	assign cy     = clamp_axis(in_q.axis_y, lim_q);

	// link watchdog, age wraps modulo 2^32
	assign age  = in_q.time_ms - last_stamp_q;
	assign lost = age > 32'(cfg.timeout_ms);

	always_comb begin
		case (cmd.axis)
			jvc_pkg::AXIS_X: sel = sx_q;
			jvc_pkg::AXIS_Y: sel = sy_q;
			default:         sel = sr_q;
		endcase
	end
	assign neg_sel  = -sel;
	assign mag      = sel[SW-1] ? neg_sel[MW-1:0] : sel[MW-1:0];
	assign gain_sel = (cmd.axis == jvc_pkg::AXIS_ROT) ? cfg.turn_gain : cfg.linear_gain;
	assign dvd      = p2_q[P2W-1:jvc_pkg::QUO_W];

	generate
		if (POW2) begin : g_shift
			assign quo      = jvc_pkg::QUO_W'(dvd >> (2 * LOGW));
			assign div_done = 1'b1;
		end else begin : g_recip
			localparam int TSH = $clog2(K + 1) - 1;
			localparam int RW  = $clog2(K + 1) + 2;
			localparam logic [23:0] RECIP = 24'((64'd1 << (TSH + 24)) / 64'(K));
			logic [23:0]   top;
			logic [47:0]   prod_q;
			logic [23:0]   est;
			logic [23:0]   est_q;
			logic [RW-1:0] rem_q;
			logic [1:0]    fix;
			logic          pend_q;

			// reciprocal estimate falls short by at most two, the remainder sets it right
			assign top = 24'(dvd >> TSH);
			assign est = prod_q[47:24];
			assign fix = (rem_q >= RW'(2 * K)) ? 2'd2 : ((rem_q >= RW'(K)) ? 2'd1 : 2'd0);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					pend_q <= 1'b0;
				end else if (cmd.div_init) begin
					pend_q <= 1'b1;
				end else if (cmd.div_step) begin
					pend_q <= 1'b0;
				end
			end

			always_ff @(posedge clk) begin
				if (cmd.div_init) begin
					prod_q <= 48'(top) * 48'(RECIP);
				end
				if (cmd.div_step) begin
					est_q <= est;
					rem_q <= RW'(dvd) - RW'(RW'(est) * RW'(K));
				end
			end

			assign quo      = jvc_pkg::QUO_W'(est_q + 24'(fix));
			assign div_done = !pend_q;
		end
	endgenerate

	// magnitude stays below 2^23, so no saturation is reachable
	assign quo_ext = jvc_pkg::VEL_W'(quo);
	assign res     = neg_q ? (-quo_ext) : quo_ext;

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= item;
		end
		if (cmd.calc_lim) begin
			lim_q <= in_q.slow_button ? slow_p[jvc_pkg::SLOW_SHIFT +: jvc_pkg::SPEED_W]
				: cfg.max_speed;
		end
		if (cmd.tick) begin
			kind_q <= jvc_pkg::KIND_STOP;
		end
		if (cmd.push) begin
			kind_q <= in_q.enable_button ? jvc_pkg::KIND_DRIVE : jvc_pkg::KIND_ZERO;
		end
		if (cmd.tick || cmd.push) begin
			lx_q <= '0;
			ly_q <= '0;
			az_q <= '0;
		end
		if (cmd.sq) begin
			p1_q  <= P1W'(mag) * P1W'(mag);
			neg_q <= sel[SW-1];
		end
		if (cmd.gain) begin
			p2_q <= P2W'(p1_q) * P2W'(gain_sel) + HALF;
		end
		if (cmd.store) begin
			case (cmd.axis)
				jvc_pkg::AXIS_X: lx_q <= res;
				jvc_pkg::AXIS_Y: ly_q <= res;
				default:         az_q <= res;
			endcase
		end
		if (cmd.emit) begin
			vel_q.kind  <= kind_q;
			vel_q.lin_x <= lx_q;
			vel_q.lin_y <= ly_q;
			vel_q.ang_z <= az_q;
		end
	end

	// window history, running sums and link state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				hx_q[i] <= '0;
				hy_q[i] <= '0;
				hr_q[i] <= '0;
			end
			sx_q         <= '0;
			sy_q         <= '0;
			sr_q         <= '0;
			last_stamp_q <= '0;
			link_lost_q  <= 1'b0;
			zero_sent_q  <= 1'b0;
		end else begin
			if (cmd.push) begin
				for (int i = 1; i < WINDOW; i++) begin
					hx_q[i] <= hx_q[i-1];
					hy_q[i] <= hy_q[i-1];
					hr_q[i] <= hr_q[i-1];
				end
				hx_q[0] <= cx;
				hy_q[0] <= cy;
				hr_q[0] <= in_q.axis_rot;
				sx_q <= sx_q + SW'(cx) - SW'(hx_q[WINDOW-1]);
				sy_q <= sy_q + SW'(cy) - SW'(hy_q[WINDOW-1]);
				sr_q <= sr_q + SW'(in_q.axis_rot) - SW'(hr_q[WINDOW-1]);
				last_stamp_q <= in_q.time_ms;
				if (in_q.enable_button) begin
					zero_sent_q <= 1'b0;
				end else if (!zero_sent_q && !link_lost_q) begin
					zero_sent_q <= 1'b1;
				end
			end
			if (cmd.tick) begin
				link_lost_q <= lost;
			end
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			vel_valid_q <= 1'b1;
		end else if (!vel_stall) begin
			vel_valid_q <= 1'b0;
		end
	end

	assign vel_valid = vel_valid_q;
	assign vel       = vel_q;

	assign sts.is_tick  = (in_q.cmd == jvc_pkg::CMD_TICK);
	assign sts.send     = sts.is_tick ? lost : (in_q.enable_button || !zero_sent_q);
	assign sts.curve    = in_q.enable_button;
	assign sts.div_done = div_done;
	assign sts.out_free = !vel_valid_q || !vel_stall;

endmodule

// ----- hdl/joystick_velocity_conditioner_core.sv -----
// top level of the joystick velocity conditioner
// depends on jvc_pkg, jvc_regs, jvc_ctrl and jvc_dp
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+------------------------------
//  item     | item_valid / item_stall      | jvc_pkg::in_t: sample or tick
//  vel      | vel_valid  / vel_stall       | jvc_pkg::out_t: velocity beat
//  config   | psel penable pwrite / pready | paddr, pwdata, prdata
//
// one item at a time: a drive sample gives its beat after the square and gain multipliers
// and the window divide have stepped through the three axes, the divide taking a
// reciprocal step when WINDOW is not a power of two; ticks and released samples skip the
// curve and give a beat only when one is due, and the next item is taken once the controller is back in idle.
// reset clears the window history, sums, link state, the configuration registers and the
// beat valid flag; a stalled beat waits in the output register while the next item is accepted.
module joystick_velocity_conditioner_core #(
	parameter int WINDOW = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  jvc_pkg::in_t               item,
	output logic                       vel_valid,
	input  logic                       vel_stall,
	output jvc_pkg::out_t              vel,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [jvc_pkg::APB_AW-1:0] paddr,
	input  logic [jvc_pkg::APB_DW-1:0] pwdata,
	output logic [jvc_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);

	jvc_pkg::cfg_t cfg;
	jvc_pkg::cmd_t cmd;
	jvc_pkg::sts_t sts;
	logic          busy;

	assign item_stall = busy;

	jvc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	jvc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.busy       (busy),
		.sts        (sts),
		.cmd        (cmd)
	);

	jvc_dp #(
		.WINDOW (WINDOW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg       (cfg),
		.cmd       (cmd),
		.sts       (sts),
		.vel_stall (vel_stall),
		.vel_valid (vel_valid),
		.vel       (vel)
	);

endmodule
